@@ sv/fsdr_pkg.sv @@
package fsdr_pkg;

  localparam int unsigned DigitCount = 4;
  localparam logic [15:0] MaxValue   = 16'd9999;
  localparam logic [7:0]  DarkPat    = 8'hFF;
  localparam logic [7:0]  FirstSel   = 8'h01;
  localparam logic [7:0]  NoSel      = 8'h00;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_REFRESH = 2'd1,
    CMD_BLANK   = 2'd2
  } cmd_e;

  typedef logic [DigitCount-1:0][7:0] pats_t;

  // common-anode, active-low segment codes
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'hC0;
      4'd1:    pat = 8'hF9;
      4'd2:    pat = 8'hA4;
      4'd3:    pat = 8'hB0;
      4'd4:    pat = 8'h99;
      4'd5:    pat = 8'h92;
      4'd6:    pat = 8'h82;
      4'd7:    pat = 8'hF8;
      4'd8:    pat = 8'h80;
      4'd9:    pat = 8'h90;
      default: pat = DarkPat;
    endcase
    return pat;
  endfunction

endpackage

@@ sv/fsdr_digits.sv @@
module fsdr_digits (
  input  logic [15:0]   number_i,
  output logic          in_range_o,
  output fsdr_pkg::pats_t patterns_o
);
  import fsdr_pkg::*;

  logic [13:0] num;
  logic [29:0] prod1;
  logic [26:0] prod2;
  logic [28:0] prod3;
  logic [9:0]  q1;
  logic [6:0]  q2;
  logic [3:0]  q3;
  logic [13:0] r0;
  logic [9:0]  r1;
  logic [6:0]  r2;

  assign num        = number_i[13:0];
  assign in_range_o = (number_i <= MaxValue);

  // reciprocal multiplies, exact for values up to 9999
  assign prod1 = 30'(num) * 30'd52429;
  assign prod2 = 27'(num) * 27'd5243;
  assign prod3 = 29'(num) * 29'd16778;
  assign q1    = prod1[28:19];
  assign q2    = prod2[25:19];
  assign q3    = prod3[27:24];

  assign r0 = num - ((14'(q1) << 3) + (14'(q1) << 1));
  assign r1 = q1 - ((10'(q2) << 3) + (10'(q2) << 1));
  assign r2 = q2 - ((7'(q3) << 3) + (7'(q3) << 1));

  assign patterns_o[0] = seg_code(r0[3:0]);
  assign patterns_o[1] = seg_code(r1[3:0]);
  assign patterns_o[2] = seg_code(r2[3:0]);
  assign patterns_o[3] = seg_code(q3);

endmodule

@@ sv/four_digit_seven_segment_refresh.sv @@
// Four-digit seven-segment refresh block, active-low common-anode display.
// Input channel: command_i / number_i under in_valid_i / in_stall_o. A write
// stores the four digit patterns of a number up to 9999 (larger values are
// dropped); a refresh emits four words, ones digit first; a blank emits one
// dark, unlatched word; command 3 is dropped.
// Output channel: segment_byte_o, select_byte_o, latch_pulse_o, last_word_o
// under out_valid_o / out_stall_i, one word per accepted cycle.
// An accepted request is held in the input register and then loaded into the
// word emitter, which presents its first word; a busy emitter holds it there.
// Writes and dropped commands never wait in the input register, so they flow
// one per cycle; back-to-back blanks flow one per cycle while the receiver does
// not stall; a refresh holds the word emitter until its last word is accepted.
// A request is taken while the previous words are still being delivered;
// the emitter works from a snapshot of the patterns, so later writes do not
// disturb a refresh in flight. While the receiver stalls, the current word
// holds and a refresh or blank waiting in the input register stalls input.
// Reset clears both valid flags and sets all four patterns to dark (0xFF).
module four_digit_seven_segment_refresh (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  segment_byte_o,
  output logic [7:0]  select_byte_o,
  output logic        latch_pulse_o,
  output logic        last_word_o
);
  import fsdr_pkg::*;

  logic        s1_valid_q;
  logic [1:0]  s1_cmd_q;
  logic [15:0] s1_num_q;

  pats_t       store_q;
  pats_t       new_pats;
  logic        in_range;

  logic        busy_q;
  logic        blank_q;
  logic [1:0]  idx_q;
  pats_t       pat_q;
  logic [7:0]  sel_q;

  logic        in_accept;
  logic        emit_free;
  logic        s1_emits;
  logic        s1_adv;
  logic        do_load;
  logic        out_accept;

  fsdr_digits u_digits (
    .number_i   (s1_num_q),
    .in_range_o (in_range),
    .patterns_o (new_pats)
  );

  assign out_accept = busy_q && !out_stall_i;
  assign emit_free  = !busy_q || (!out_stall_i && last_word_o);
  assign s1_emits   = (s1_cmd_q == CMD_REFRESH) || (s1_cmd_q == CMD_BLANK);
  assign s1_adv     = s1_valid_q && (!s1_emits || emit_free);
  assign do_load    = s1_adv && s1_emits;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q <= command_i;
      s1_num_q <= number_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= {DigitCount{DarkPat}};
    end else if (s1_adv && (s1_cmd_q == CMD_WRITE) && in_range) begin
      store_q <= new_pats;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (do_load) begin
      busy_q <= 1'b1;
    end else if (out_accept && last_word_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      if (s1_cmd_q == CMD_BLANK) begin
        blank_q <= 1'b1;
        pat_q   <= {DigitCount{DarkPat}};
        sel_q   <= NoSel;
      end else begin
        blank_q <= 1'b0;
        pat_q   <= store_q;
        sel_q   <= FirstSel;
      end
      idx_q <= '0;
    end else if (out_accept) begin
      // advance to the next digit
      pat_q <= {DarkPat, pat_q[DigitCount-1:1]};
      sel_q <= sel_q << 1;
      idx_q <= idx_q + 2'd1;
    end
  end

  assign out_valid_o    = busy_q;
  assign segment_byte_o = pat_q[0];
  assign select_byte_o  = sel_q;
  assign latch_pulse_o  = !blank_q;
  assign last_word_o    = blank_q || (idx_q == 2'(DigitCount - 1));

  a_blank_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !latch_pulse_o |-> select_byte_o == NoSel && last_word_o)
    else $error("blank word malformed");

  a_select_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && latch_pulse_o |-> $onehot(select_byte_o))
    else $error("refresh select not one-hot");

  a_refresh_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_word_o |=> out_valid_o && latch_pulse_o)
    else $error("refresh sequence broken");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_emits && busy_q)
    else $error("input stalled without a pending request");

endmodule

@@ sim/tb_four_digit_seven_segment_refresh.sv @@
`timescale 1ns / 100ps

module tb_four_digit_seven_segment_refresh;
  import fsdr_pkg::*;

  localparam logic [1:0] CmdUnused  = 2'd3;
  localparam int         IdleLimit  = 1000;
  localparam int         RandomReqs = 100;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] num;
    int          gap;
    bit          drain;
  } request_t;

  typedef struct {
    logic [7:0] seg;
    logic [7:0] sel;
    logic       latch;
    logic       last;
  } display_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command = CMD_WRITE;
  logic [15:0] number = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [7:0]  segment_byte_o;
  logic [7:0]  select_byte_o;
  logic        latch_pulse_o;
  logic        last_word_o;

  request_t      pending_reqs[$];
  display_word_t words_due[$];
  logic [7:0]    shown_pats[DigitCount];

  logic [7:0] seg_lut[10] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                              8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};

  int  words_predicted = 0;
  int  words_checked = 0;
  int  idle_cycles = 0;
  int  mismatches = 0;
  int  n_write = 0, n_over = 0, n_refresh = 0, n_blank = 0, n_unused = 0;
  int  gap_left = 0;
  bit  gap_armed = 1'b0;
  int  stall_left = 0;
  int  cyc = 0;

  four_digit_seven_segment_refresh DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .command_i      (command),
    .number_i       (number),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .segment_byte_o (segment_byte_o),
    .select_byte_o  (select_byte_o),
    .latch_pulse_o  (latch_pulse_o),
    .last_word_o    (last_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_req(logic [1:0] cmd, logic [15:0] num, int gap, bit drain);
    request_t r;
    r.cmd   = cmd;
    r.num   = num;
    r.gap   = gap;
    r.drain = drain;
    pending_reqs.push_back(r);
  endfunction

  // Update the digit store and queue the words a request produces.
  task automatic predict_display(input logic [1:0] cmd, input logic [15:0] num,
                                 output int n_words);
    display_word_t w;
    int            v;
    n_words = 0;
    case (cmd)
      CMD_WRITE: begin
        n_write++;
        if (num > MaxValue) begin
          n_over++;
        end else begin
          v = num;
          for (int i = 0; i < DigitCount; i++) begin
            shown_pats[i] = seg_lut[v % 10];
            v = v / 10;
          end
        end
      end
      CMD_REFRESH: begin
        n_refresh++;
        for (int i = 0; i < DigitCount; i++) begin
          w.seg   = shown_pats[i];
          w.sel   = 8'(1 << i);
          w.latch = 1'b1;
          w.last  = (i == DigitCount - 1);
          words_due.push_back(w);
        end
        n_words = DigitCount;
      end
      CMD_BLANK: begin
        n_blank++;
        w.seg   = DarkPat;
        w.sel   = NoSel;
        w.latch = 1'b0;
        w.last  = 1'b1;
        words_due.push_back(w);
        n_words = 1;
      end
      default: n_unused++;
    endcase
  endtask

  // Sender: hold a stalled request; else wait out gap, drain if flagged, send next.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    request_t r;
    logic     next_valid;
    logic     took;
    int       wait_n;
    bit       armed;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      command   <= CMD_WRITE;
      number    <= '0;
      gap_left  <= 0;
      gap_armed <= 1'b0;
    end else begin
      took       = in_valid && !in_stall_o;
      next_valid = in_valid && !took;
      wait_n     = gap_left;
      armed      = gap_armed;
      if (!next_valid && pending_reqs.size() > 0) begin
        if (!armed) begin
          wait_n = pending_reqs[0].gap;
          armed  = 1'b1;
        end
        if (wait_n > 0) begin
          wait_n--;
        end else if (!pending_reqs[0].drain ||
                     (!took && words_predicted == words_checked)) begin
          r          = pending_reqs.pop_front();
          next_valid = 1'b1;
          armed      = 1'b0;
          command    <= r.cmd;
          number     <= r.num;
        end
      end
      in_valid  <= next_valid;
      gap_left  <= wait_n;
      gap_armed <= armed;
    end
  end

  // Receiver: stall a random number of cycles after each word, with quiet stretches.
  always @(posedge clk_i or negedge rst_ni) begin : drive_stall
    int n;
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      cyc        <= 0;
    end else begin
      n = stall_left;
      if (out_valid_o && !out_stall) begin
        n = (cyc[8:7] == 2'b00) ? 0 : $urandom_range(0, 7);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        n--;
      end else begin
        out_stall <= 1'b0;
      end
      stall_left <= n;
      cyc        <= cyc + 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_words
    display_word_t w;
    int            n_new;
    logic          in_take;
    logic          out_take;
    if (!rst_ni) begin
      for (int i = 0; i < DigitCount; i++) shown_pats[i] = DarkPat;
      idle_cycles <= 0;
    end else begin
      in_take  = in_valid && !in_stall_o;
      out_take = out_valid_o && !out_stall;
      n_new    = 0;
      if (in_take) predict_display(command, number, n_new);
      if (out_take) begin
        if (words_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word seg %h sel %h latch %b last %b", $time,
                   segment_byte_o, select_byte_o, latch_pulse_o, last_word_o);
        end else begin
          w = words_due.pop_front();
          if (segment_byte_o !== w.seg) begin
            mismatches++;
            $display("%0t: segment_byte expected %h actual %h", $time, w.seg, segment_byte_o);
          end
          if (select_byte_o !== w.sel) begin
            mismatches++;
            $display("%0t: select_byte expected %h actual %h", $time, w.sel, select_byte_o);
          end
          if (latch_pulse_o !== w.latch) begin
            mismatches++;
            $display("%0t: latch_pulse expected %b actual %b", $time, w.latch, latch_pulse_o);
          end
          if (last_word_o !== w.last) begin
            mismatches++;
            $display("%0t: last_word expected %b actual %b", $time, w.last, last_word_o);
          end
        end
      end
      words_predicted <= words_predicted + n_new;
      words_checked   <= words_checked + (out_take ? 1 : 0);
      idle_cycles     <= (in_take || out_take) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    int  r;
    int  gap;
    bit  timed_out;
    timed_out = 1'b0;

    // directed: dark store after reset, extremes, ignored values, leading zeros
    add_req(CMD_REFRESH, 16'h0000, 0, 1'b0);
    add_req(CMD_BLANK,   16'hFFFF, 0, 1'b0);
    add_req(CMD_WRITE,   16'd0,    0, 1'b0);
    add_req(CMD_REFRESH, 16'd0,    0, 1'b0);
    add_req(CMD_WRITE,   16'd9999, 2, 1'b0);
    add_req(CMD_REFRESH, 16'hFFFF, 0, 1'b0);
    add_req(CMD_WRITE,   16'd10000, 0, 1'b0);
    add_req(CMD_REFRESH, 16'd0,    1, 1'b0);
    add_req(CMD_WRITE,   16'd1234, 0, 1'b0);
    add_req(CMD_WRITE,   16'hFFFF, 0, 1'b0);
    add_req(CMD_REFRESH, 16'd0,    0, 1'b0);
    add_req(CMD_WRITE,   16'd5,    3, 1'b0);
    add_req(CMD_REFRESH, 16'd0,    0, 1'b0);
    add_req(CmdUnused,   16'hFFFF, 0, 1'b0);
    add_req(CMD_REFRESH, 16'd0,    0, 1'b0);
    add_req(CMD_WRITE,   16'd8765, 0, 1'b0);
    add_req(CmdUnused,   16'd0,    0, 1'b0);
    add_req(CMD_REFRESH, 16'd0,    0, 1'b0);
    add_req(CMD_WRITE,   16'd4090, 0, 1'b1);
    add_req(CMD_BLANK,   16'd0,    0, 1'b0);
    add_req(CMD_REFRESH, 16'd0,    0, 1'b0);

    for (int i = 0; i < RandomReqs; i++) begin
      gap = ((i / 20) % 2 == 1) ? 0 : $urandom_range(0, 7);
      r   = $urandom_range(0, 99);
      if (r < 35)      add_req(CMD_WRITE, 16'($urandom_range(0, 9999)), gap, i == 60);
      else if (r < 42) add_req(CMD_WRITE, 16'($urandom_range(10000, 65535)), gap, i == 60);
      else if (r < 80) add_req(CMD_REFRESH, 16'($urandom), gap, i == 60);
      else if (r < 92) add_req(CMD_BLANK, 16'($urandom), gap, i == 60);
      else             add_req(CmdUnused, 16'($urandom), gap, i == 60);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every request to go in and every word to come out
    while (!timed_out && (pending_reqs.size() > 0 || in_valid || words_due.size() > 0)) begin
      @(negedge clk_i);
      if (idle_cycles >= IdleLimit) timed_out = 1'b1;
    end
    if (!timed_out) repeat (8) @(negedge clk_i);

    if (timed_out) begin
      $display("Mismatches found");
    end else begin
      if (words_due.size() > 0) begin
        mismatches++;
        $display("%0t: %0d expected words never arrived", $time, words_due.size());
      end
      $display("Run: %0d writes (%0d over range), %0d refreshes, %0d blanks, %0d unused",
               n_write, n_over, n_refresh, n_blank, n_unused);
      $display("Checked %0d display words against the prediction", words_checked);
      if (mismatches == 0) begin
        $display("No mismatches found");
      end else begin
        $display("Mismatches found");
      end
    end
    $finish;
  end

endmodule
